@@ rtl/fixed_point_decimal_format_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the fixed-point decimal formatter
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_DECIMAL_FORMAT_DEFINES_SVH
`define FIXED_POINT_DECIMAL_FORMAT_DEFINES_SVH

// Same-cycle implication.
`define FPDF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fpdf same-cycle check failed");

// Next-cycle implication.
`define FPDF_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fpdf next-cycle check failed");

`endif

@@ rtl/fpdf_pkg.sv @@
// ---------------------------------------------------------------------------
// fpdf_pkg
// Widths, ASCII codes, reciprocal constants and pipeline payload types
// for the fixed-point decimal formatter.
// ---------------------------------------------------------------------------
package fpdf_pkg;

   localparam int unsigned VALUE_W = 18;   // signed input in hundredths
   localparam int unsigned FULL_W  = 18;   // magnitude incl. -2^17
   localparam int unsigned MAG_W   = 17;   // magnitude when in range
   localparam int unsigned HI_W    = 7;    // magnitude / 1000, 0..99
   localparam int unsigned LO_W    = 10;   // magnitude % 1000
   localparam int unsigned REM_W   = 7;    // magnitude % 100
   localparam int unsigned DIGIT_W = 4;
   localparam int unsigned CHAR_W  = 8;

   localparam logic [FULL_W-1:0] MAG_LIMIT = 18'd99999;

   // x / 1000 = (x * 134218) >> 27, exact for x below 2^17
   localparam int unsigned       DIV1000_P_W   = 35;
   localparam int unsigned       DIV1000_SHIFT = 27;
   localparam logic [17:0]       DIV1000_MUL   = 18'd134218;
   localparam logic [MAG_W-1:0]  THOUSAND      = 17'd1000;

   // x / 100 = (x * 41) >> 12, exact for x below 1000
   localparam int unsigned       DIV100_P_W    = 16;
   localparam int unsigned       DIV100_SHIFT  = 12;
   localparam logic [5:0]        DIV100_MUL    = 6'd41;
   localparam logic [LO_W-1:0]   HUNDRED       = 10'd100;

   // x / 10 = (x * 205) >> 11, exact for x below 100
   localparam int unsigned       DIV10_P_W     = 15;
   localparam int unsigned       DIV10_SHIFT   = 11;
   localparam logic [7:0]        DIV10_MUL     = 8'd205;
   localparam logic [HI_W-1:0]   TEN           = 7'd10;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   typedef logic [CHAR_W-1:0] char_type;

   // Payload that walks down the digit pipeline; fields fill in stage by stage.
   typedef struct packed {
      logic               neg;
      logic               oor;
      logic [MAG_W-1:0]   mag;
      logic [HI_W-1:0]    q1;        // magnitude / 1000
      logic [LO_W-1:0]    lo;        // magnitude % 1000
      logic [DIGIT_W-1:0] dig_hun;   // hundreds digit of the number
      logic [DIGIT_W-1:0] dig_ten;
      logic [DIGIT_W-1:0] dig_one;
      logic [REM_W-1:0]   rem;       // magnitude % 100
      logic [DIGIT_W-1:0] dig_tth;   // tenths digit
   } work_type;

   typedef struct packed {
      char_type c0;
      char_type c1;
      char_type c2;
      char_type c3;
      char_type c4;
      char_type c5;
      char_type c6;
      logic     oor;
   } rsp_type;

endpackage

@@ rtl/fpdf_channels.sv @@
// ---------------------------------------------------------------------------
// fpdf channels
// Valid/ready channel interfaces for the formatter's input and result.
// ---------------------------------------------------------------------------
interface fpdf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [fpdf_pkg::VALUE_W-1:0] value_hundredths;

   modport source (output valid, output value_hundredths, input ready);
   modport sink   (input valid, input value_hundredths, output ready);
endinterface

interface fpdf_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [fpdf_pkg::CHAR_W-1:0] char_sign_or_hundreds;
   logic [fpdf_pkg::CHAR_W-1:0] char_pos1;
   logic [fpdf_pkg::CHAR_W-1:0] char_pos2;
   logic [fpdf_pkg::CHAR_W-1:0] char_units;
   logic [fpdf_pkg::CHAR_W-1:0] char_point;
   logic [fpdf_pkg::CHAR_W-1:0] char_tenths;
   logic [fpdf_pkg::CHAR_W-1:0] char_hundredths;
   logic                     out_of_range;

   modport source (output valid, output char_sign_or_hundreds, output char_pos1,
                   output char_pos2, output char_units, output char_point,
                   output char_tenths, output char_hundredths, output out_of_range,
                   input ready);
   modport sink   (input valid, input char_sign_or_hundreds, input char_pos1,
                   input char_pos2, input char_units, input char_point,
                   input char_tenths, input char_hundredths, input out_of_range,
                   output ready);
endinterface

@@ rtl/fpdf_digit_pipe.sv @@
// ---------------------------------------------------------------------------
// fpdf_digit_pipe
// Five-stage digit extraction by constant reciprocals, one or two constant
// multiplies per stage, with per-stage valid and local stall control.
// ---------------------------------------------------------------------------
module fpdf_digit_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fpdf_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output fpdf_pkg::work_type out_data
);
   import fpdf_pkg::*;

   localparam int unsigned NSTAGE = 5;

   function automatic work_type stage_op(input int unsigned idx, input work_type w);
      work_type                r;
      logic [DIV1000_P_W-1:0]  p_k;
      logic [DIV100_P_W-1:0]   p_h;
      logic [DIV10_P_W-1:0]    p_t;
      r   = w;
      p_k = '0;
      p_h = '0;
      p_t = '0;
      unique case (idx)
         0: begin
            p_k  = DIV1000_P_W'(w.mag) * DIV1000_P_W'(DIV1000_MUL);
            r.q1 = p_k[DIV1000_SHIFT +: HI_W];
         end
         1: begin
            r.lo      = LO_W'(w.mag - MAG_W'(w.q1) * THOUSAND);
            p_t       = DIV10_P_W'(w.q1) * DIV10_P_W'(DIV10_MUL);
            r.dig_hun = p_t[DIV10_SHIFT +: DIGIT_W];
         end
         2: begin
            r.dig_ten = DIGIT_W'(w.q1 - HI_W'(w.dig_hun) * TEN);
            p_h       = DIV100_P_W'(w.lo) * DIV100_P_W'(DIV100_MUL);
            r.dig_one = p_h[DIV100_SHIFT +: DIGIT_W];
         end
         3: begin
            r.rem = REM_W'(w.lo - LO_W'(w.dig_one) * HUNDRED);
         end
         4: begin
            p_t       = DIV10_P_W'(w.rem) * DIV10_P_W'(DIV10_MUL);
            r.dig_tth = p_t[DIV10_SHIFT +: DIGIT_W];
         end
         default: r = w;
      endcase
      return r;
   endfunction

   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE-1:0] load;
   logic [NSTAGE-1:0] up_vld;
   logic [NSTAGE-1:0] dn_rdy;
   work_type          data_ff [NSTAGE];
   work_type          up_data [NSTAGE];

   always_comb begin
      up_vld[0]  = in_valid;
      up_data[0] = in_data;
      for (int k = 1; k < NSTAGE; k++) begin
         up_vld[k]  = vld_ff[k-1];
         up_data[k] = data_ff[k-1];
      end
      // ready ripples back from the output, so walk the stages from the last
      dn_rdy[NSTAGE-1] = out_ready;
      for (int k = NSTAGE-2; k >= 0; k--) begin
         dn_rdy[k] = !vld_ff[k+1] || dn_rdy[k+1];
      end
      for (int k = 0; k < NSTAGE; k++) begin
         // a stage takes a new item when it is empty or its item moves on
         load[k]   = !vld_ff[k] || dn_rdy[k];
         vld_in[k] = load[k] ? up_vld[k] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
      always_ff @(posedge clock) begin
         if (load[g] && up_vld[g]) begin
            data_ff[g] <= stage_op(g, up_data[g]);
         end
      end
   end

   assign in_ready  = load[0];
   assign out_valid = vld_ff[NSTAGE-1];
   assign out_data  = data_ff[NSTAGE-1];

endmodule

@@ rtl/fixed_point_decimal_format.sv @@
// ---------------------------------------------------------------------------
// fixed_point_decimal_format
// Signed hundredths to a seven-character ASCII field "sddd.dd".
// ---------------------------------------------------------------------------
// Takes one signed 18-bit value in hundredths per transfer and returns one
// seven-character ASCII field plus an out-of-range flag per transfer, in
// order. Leading zero hundreds and tens digits print as spaces, the minus
// sign sits just before the first digit shown, and the ones digit always
// prints. Magnitudes above 99999 give " ***.**" with out_of_range set.
// Throughput is one value per clock while the result channel takes results;
// each value passes seven register stages (magnitude, five digit stages
// by reciprocal multiply, character output), and the first of them loads
// on the input transfer edge itself.
// Backpressure on the result channel stalls the stages locally; empty
// stages keep filling, so a waiting result blocks new input only once all
// seven stages hold items.
// ---------------------------------------------------------------------------
`include "fixed_point_decimal_format_defines.svh"

module fixed_point_decimal_format (
   input  logic              clock,
   input  logic              reset,
   fpdf_req_if.sink          req_chan,
   fpdf_rsp_if.source        rsp_chan
);
   import fpdf_pkg::*;

   // ---------------- stage 1: magnitude and range check ----------------
   logic              s1_vld_ff;
   logic              s1_vld_in;
   work_type          s1_data_ff;
   work_type          s1_data_in;
   logic              s1_load;
   logic              neg;
   logic [FULL_W-1:0] mag_full;

   logic              pipe_in_ready;
   logic              pipe_out_valid;
   work_type          pipe_out_data;

   logic              out_load;

   always_comb begin
      neg      = req_chan.value_hundredths[VALUE_W-1];
      mag_full = neg ? FULL_W'(-req_chan.value_hundredths)
                     : FULL_W'(req_chan.value_hundredths);
      s1_data_in     = '0;
      s1_data_in.neg = neg;
      s1_data_in.oor = mag_full > MAG_LIMIT;
      // drop the top bit: it is only set when the value is out of range
      s1_data_in.mag = mag_full[MAG_W-1:0];
   end

   // hold while the digit pipe refuses the item, otherwise advance
   assign s1_load   = !s1_vld_ff || pipe_in_ready;
   assign s1_vld_in = s1_load ? req_chan.valid : s1_vld_ff;
   assign req_chan.ready = s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_chan.valid) begin
         s1_data_ff <= s1_data_in;
      end
   end

   // ---------------- stages 2 to 6: digit extraction ----------------
   fpdf_digit_pipe u_digit_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_ready  (pipe_in_ready),
      .in_data   (s1_data_ff),
      .out_valid (pipe_out_valid),
      .out_ready (out_load),
      .out_data  (pipe_out_data)
   );

   // ---------------- stage 7: last digit and character layout ----------------
   logic               rsp_vld_ff;
   logic               rsp_vld_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic [DIGIT_W-1:0] dig_hth;
   logic               show_hun;
   logic               show_ten;
   char_type           sign_ch;

   always_comb begin
      dig_hth  = DIGIT_W'(pipe_out_data.rem - REM_W'(pipe_out_data.dig_tth) * REM_W'(TEN));
      show_hun = pipe_out_data.dig_hun != '0;      // magnitude at least 10000
      show_ten = pipe_out_data.q1 != '0;           // magnitude at least 1000
      sign_ch  = pipe_out_data.neg ? CH_MINUS : CH_SPACE;

      rsp_in.c4  = CH_POINT;
      rsp_in.oor = pipe_out_data.oor;
      if (pipe_out_data.oor) begin
         rsp_in.c0 = CH_SPACE;
         rsp_in.c1 = CH_STAR;
         rsp_in.c2 = CH_STAR;
         rsp_in.c3 = CH_STAR;
         rsp_in.c5 = CH_STAR;
         rsp_in.c6 = CH_STAR;
      end else begin
         // the sign slides right to sit just before the first digit shown
         rsp_in.c0 = show_hun ? sign_ch : CH_SPACE;
         rsp_in.c1 = show_hun ? (CH_ZERO | CHAR_W'(pipe_out_data.dig_hun))
                              : (show_ten ? sign_ch : CH_SPACE);
         rsp_in.c2 = show_ten ? (CH_ZERO | CHAR_W'(pipe_out_data.dig_ten)) : sign_ch;
         rsp_in.c3 = CH_ZERO | CHAR_W'(pipe_out_data.dig_one);
         rsp_in.c5 = CH_ZERO | CHAR_W'(pipe_out_data.dig_tth);
         rsp_in.c6 = CH_ZERO | CHAR_W'(dig_hth);
      end
   end

   // output register: advance when empty or when the sink takes the transfer
   assign out_load   = !rsp_vld_ff || rsp_chan.ready;
   assign rsp_vld_in = out_load ? pipe_out_valid : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && pipe_out_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid                 = rsp_vld_ff;
   assign rsp_chan.char_sign_or_hundreds = rsp_ff.c0;
   assign rsp_chan.char_pos1             = rsp_ff.c1;
   assign rsp_chan.char_pos2             = rsp_ff.c2;
   assign rsp_chan.char_units            = rsp_ff.c3;
   assign rsp_chan.char_point            = rsp_ff.c4;
   assign rsp_chan.char_tenths           = rsp_ff.c5;
   assign rsp_chan.char_hundredths       = rsp_ff.c6;
   assign rsp_chan.out_of_range          = rsp_ff.oor;

   // ---------------- checks ----------------
   `FPDF_ASSERT_NXT(a_accept_fills_s1, req_chan.valid && req_chan.ready, s1_vld_ff)
   `FPDF_ASSERT_NXT(a_s1_holds_on_stall, s1_vld_ff && !pipe_in_ready, s1_vld_ff && s1_data_ff == $past(s1_data_ff))
   `FPDF_ASSERT_IMP(a_oor_pattern, rsp_chan.valid && rsp_chan.out_of_range, rsp_chan.char_units == CH_STAR && rsp_chan.char_sign_or_hundreds == CH_SPACE)
   `FPDF_ASSERT_IMP(a_units_is_digit, rsp_chan.valid && !rsp_chan.out_of_range, rsp_chan.char_units >= CH_ZERO && rsp_chan.char_units <= CH_NINE)
   `FPDF_ASSERT_IMP(a_sign_leads_digits, rsp_chan.valid && rsp_chan.char_pos2 == CH_MINUS, rsp_chan.char_pos1 == CH_SPACE && rsp_chan.char_sign_or_hundreds == CH_SPACE)

endmodule
